[rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg: shared definitions for the double-ended queue
// Field widths, operation codes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF     = 1024;
    localparam int WORD_BITS_DEF = 32;

    // Fixed field widths on the channels
    localparam int MODE_W      = 3;
    localparam int IO_W        = 32;
    localparam int COUNT_OUT_W = 11;

    // Operation codes; unused codes act as a query
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd4;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;   // capture the input beat
        logic exec;    // update pointers, write or issue a read
        logic fetch;   // refresh cached end words from read data
        logic load;    // load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;  // result register empty or being taken
    } stat_t;

endpackage

[rtl/deq_if.sv]
// ----------------------------------------------------------------------------
// deq_if: request and response channels of the double-ended queue
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface deq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic        [deq_pkg::MODE_W-1:0]    mode;
    logic signed [deq_pkg::IO_W-1:0]      value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface deq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [deq_pkg::IO_W-1:0]      popped_value;
    logic        [deq_pkg::COUNT_OUT_W-1:0] entry_count;
    logic                                 is_empty;
    logic signed [deq_pkg::IO_W-1:0]      front_value;
    logic signed [deq_pkg::IO_W-1:0]      back_value;
    logic                                 overflow;

    modport source (output valid, output popped_value, output entry_count,
                    output is_empty, output front_value, output back_value,
                    output overflow, input ready);
    modport sink   (input valid, input popped_value, input entry_count,
                    input is_empty, input front_value, input back_value,
                    input overflow, output ready);
endinterface

[rtl/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl: sequencing of one queue operation
// Steps each beat through execute, fetch and result load, holding the
// result step while the response register is still occupied.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  deq_pkg::stat_t  stat,
    output deq_pkg::cmd_t   cmd
);

    deq_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= deq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = deq_pkg::ST_EXEC;
                end
            end
            deq_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = deq_pkg::ST_FETCH;
            end
            deq_pkg::ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = deq_pkg::ST_DONE;
            end
            deq_pkg::ST_DONE:
            begin
                cmd.load = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = deq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/deq_datapath.sv]
// ----------------------------------------------------------------------------
// deq_datapath: circular buffer, pointers and result register
// Front and back words are cached in registers so each operation needs
// at most one write or one read of the slot memory.
// ----------------------------------------------------------------------------
module deq_datapath #(
    parameter int DEPTH     = deq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  deq_pkg::cmd_t                      cmd,
    output deq_pkg::stat_t                     stat,
    input  logic        [deq_pkg::MODE_W-1:0]  in_mode,
    input  logic signed [deq_pkg::IO_W-1:0]    in_value,
    deq_rsp_if.source                          rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef logic        [AW-1:0]        addr_t;
    typedef logic        [CW-1:0]        count_t;
    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [deq_pkg::IO_W-1:0] io_t;

    localparam addr_t  LAST_ADDR  = AW'(DEPTH - 1);
    localparam count_t FULL_COUNT = CW'(DEPTH);
    localparam count_t ONE_COUNT  = CW'(1);
    localparam io_t    NONE_WORD  = '1;

    function automatic addr_t step_up(input addr_t a);
        return (a == LAST_ADDR) ? '0 : AW'(a + 1'b1);
    endfunction

    function automatic addr_t step_down(input addr_t a);
        return (a == '0) ? LAST_ADDR : AW'(a - 1'b1);
    endfunction

    // Slot memory
    word_t mem [DEPTH];
    word_t rdata_reg;
    logic  wr_en, rd_en;
    addr_t waddr, raddr;

    // Pointer and flag state
    addr_t  head_reg, head_next;
    addr_t  tail_reg, tail_next;
    count_t count_reg, count_next;
    logic   ovf_reg, ovf_next;
    logic   pop_hit_reg, pop_hit_next;
    logic   fetch_front_reg, fetch_front_next;
    logic   fetch_back_reg, fetch_back_next;
    logic   out_valid_reg, out_valid_next;

    // Payload
    logic [deq_pkg::MODE_W-1:0] mode_reg, mode_next;
    word_t  word_reg, word_next;
    word_t  front_reg, front_next;
    word_t  back_reg, back_next;
    word_t  popped_reg, popped_next;
    io_t    out_popped_reg, out_popped_next;
    io_t    out_front_reg, out_front_next;
    io_t    out_back_reg, out_back_next;
    logic [deq_pkg::COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic   out_empty_reg, out_empty_next;
    logic   out_ovf_reg, out_ovf_next;

    logic is_full, is_empty;

    assign is_full       = (count_reg == FULL_COUNT);
    assign is_empty      = (count_reg == '0);
    assign stat.out_free = !out_valid_reg || rsp.ready;

    // Memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= word_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Operation logic
    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        pop_hit_next     = pop_hit_reg;
        fetch_front_next = fetch_front_reg;
        fetch_back_next  = fetch_back_reg;
        mode_next        = mode_reg;
        word_next        = word_reg;
        front_next       = front_reg;
        back_next        = back_reg;
        popped_next      = popped_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        waddr            = head_reg;
        raddr            = head_reg;

        // capture request beat
        if (cmd.latch)
        begin
            mode_next = in_mode;
            word_next = WORD_BITS'(in_value);
        end

        // execute
        if (cmd.exec)
        begin
            ovf_next         = 1'b0;
            pop_hit_next     = 1'b0;
            fetch_front_next = 1'b0;
            fetch_back_next  = 1'b0;
            unique case (mode_reg)
                deq_pkg::MODE_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        head_next  = step_down(head_reg);
                        wr_en      = 1'b1;
                        waddr      = head_next;
                        front_next = word_reg;
                        if (is_empty)
                        begin
                            back_next = word_reg;
                        end
                        count_next = CW'(count_reg + ONE_COUNT);
                    end
                end
                deq_pkg::MODE_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        waddr     = tail_reg;
                        tail_next = step_up(tail_reg);
                        back_next = word_reg;
                        if (is_empty)
                        begin
                            front_next = word_reg;
                        end
                        count_next = CW'(count_reg + ONE_COUNT);
                    end
                end
                deq_pkg::MODE_POP_FRONT:
                begin
                    if (!is_empty)
                    begin
                        pop_hit_next = 1'b1;
                        popped_next  = front_reg;
                        head_next    = step_up(head_reg);
                        count_next   = CW'(count_reg - ONE_COUNT);
                        // new front comes from the slot at the new head
                        if (count_reg != ONE_COUNT)
                        begin
                            rd_en            = 1'b1;
                            raddr            = head_next;
                            fetch_front_next = 1'b1;
                        end
                    end
                end
                deq_pkg::MODE_POP_BACK:
                begin
                    if (!is_empty)
                    begin
                        pop_hit_next = 1'b1;
                        popped_next  = back_reg;
                        tail_next    = step_down(tail_reg);
                        count_next   = CW'(count_reg - ONE_COUNT);
                        // new back sits one below the new tail
                        if (count_reg != ONE_COUNT)
                        begin
                            rd_en           = 1'b1;
                            raddr           = step_down(tail_next);
                            fetch_back_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // query and unused codes leave the state alone
                end
            endcase
        end

        // refresh cached end word
        if (cmd.fetch)
        begin
            if (fetch_front_reg)
            begin
                front_next = rdata_reg;
            end
            if (fetch_back_reg)
            begin
                back_next = rdata_reg;
            end
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_popped_next = out_popped_reg;
        out_front_next  = out_front_reg;
        out_back_next   = out_back_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;
        out_ovf_next    = out_ovf_reg;
        if (cmd.load)
        begin
            out_valid_next  = 1'b1;
            out_popped_next = pop_hit_reg ? deq_pkg::IO_W'(popped_reg) : NONE_WORD;
            out_front_next  = is_empty ? NONE_WORD : deq_pkg::IO_W'(front_reg);
            out_back_next   = is_empty ? NONE_WORD : deq_pkg::IO_W'(back_reg);
            out_count_next  = deq_pkg::COUNT_OUT_W'(count_reg);
            out_empty_next  = is_empty;
            out_ovf_next    = ovf_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
            pop_hit_reg     <= 1'b0;
            fetch_front_reg <= 1'b0;
            fetch_back_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            ovf_reg         <= ovf_next;
            pop_hit_reg     <= pop_hit_next;
            fetch_front_reg <= fetch_front_next;
            fetch_back_reg  <= fetch_back_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        word_reg       <= word_next;
        front_reg      <= front_next;
        back_reg       <= back_next;
        popped_reg     <= popped_next;
        out_popped_reg <= out_popped_next;
        out_front_reg  <= out_front_next;
        out_back_reg   <= out_back_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
        out_ovf_reg    <= out_ovf_next;
    end

    // Response channel
    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_value = out_popped_reg;
    assign rsp.entry_count  = out_count_reg;
    assign rsp.is_empty     = out_empty_reg;
    assign rsp.front_value  = out_front_reg;
    assign rsp.back_value   = out_back_reg;
    assign rsp.overflow     = out_ovf_reg;

endmodule

[rtl/double_ended_queue_core.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_core: double-ended queue on a circular buffer
// Each request beat carries a mode (push front, push back, pop front,
// pop back, query) and a word; each gives exactly one response beat with
// the popped word, the count, an empty flag, the front and back words and
// an overflow flag for a push into a full queue.
//
// After a request beat is taken the sequence is execute (pointer
// update and slot write or read), fetch (registered read data refreshes
// the cached end word), result load, then a return to accept; no new
// beat is accepted until the sequence is back at accept.
// The next request is accepted while an earlier response still waits in
// the output register; if the receiver holds ready low, the block stops
// at the result load of that next beat until the register drains.
// Reset clears the pointers, the count and the response valid; the queue
// is empty afterward and accepts at once. Slot contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
    parameter int DEPTH     = deq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);

    deq_pkg::cmd_t  cmd;
    deq_pkg::stat_t stat;

    // Sequencer
    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and result path
    deq_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_mode  (req.mode),
        .in_value (req.value),
        .rsp      (rsp)
    );

endmodule
